/* design/average_pool_3d_by_two_top_macros.svh */
// assertion helpers shared by the pooling block
// every macro samples on i_clk and is switched off while i_rst_n is low
`ifndef AVERAGE_POOL_3D_BY_TWO_TOP_MACROS_SVH
`define AVERAGE_POOL_3D_BY_TWO_TOP_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define AP3_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define AP3_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/ap3_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package ap3_pkg;

    // default sizing of the block
    localparam int DEF_MAX_CHAN    = 16;
    localparam int DEF_MAX_WIDTH   = 64;
    localparam int DEF_MAX_HEIGHT  = 64;
    localparam int DEF_SAMPLE_BITS = 16;

    // register widths
    localparam int CH_CNT_W   = 5;
    localparam int SIZE_XY_W  = 7;
    localparam int SIZE_Z_W   = 13;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 2;

    // register reset values
    localparam int RST_CHAN   = 1;
    localparam int RST_WIDTH  = 64;
    localparam int RST_HEIGHT = 64;
    localparam int RST_DEPTH  = 64;

    // depth along z is bounded independently of the store
    localparam int DEPTH_LIMIT = 4096;
    localparam int Z_POS_W     = $clog2(DEPTH_LIMIT);

    // eight samples per block, so the mean is a shift by three
    localparam int MEAN_SHIFT = 3;

    // queue depths
    localparam int QUEUE_DEPTH = 4;
    localparam int OUT_DEPTH   = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CHANNEL_COUNT = 2'd0,
        CFG_INPUT_WIDTH   = 2'd1,
        CFG_INPUT_HEIGHT  = 2'd2,
        CFG_INPUT_DEPTH   = 2'd3
    } t_cfg_reg;

    // classification of one sample, front to back
    typedef struct packed {
        logic first;
        logic last;
        logic vend;
    } t_item_flags;

    localparam int FLAGS_W = $bits(t_item_flags);

endpackage

`default_nettype wire

/* design/average_pool_3d_by_two_top.sv */
// 2x2x2 average pooling over a stream of signed samples, channel fastest, then x, y and z.
// Sustained rate is one sample per clock while the result queue has room. Every sample is a
// single read-modify-write of the partial-sum RAM, read issued as it leaves the front queue,
// written back as it retires, with a forwarding path for back-to-back samples of the same
// entry. A result is pushed when its eighth sample retires. Register writes restart the
// volume at position zero and must only be made while the block is idle. The sum store needs
// no clearing pass after reset: every entry is written by the first sample of its block.
`timescale 1ns / 1ps
`default_nettype none

module average_pool_3d_by_two_top #(
    parameter int MAX_CHAN    = ap3_pkg::DEF_MAX_CHAN,
    parameter int MAX_WIDTH   = ap3_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT  = ap3_pkg::DEF_MAX_HEIGHT,
    parameter int SAMPLE_BITS = ap3_pkg::DEF_SAMPLE_BITS
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_wr_en,
    input  wire logic [ap3_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [ap3_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                           push,
    output logic                                full,
    input  wire logic signed [SAMPLE_BITS-1:0]  i_sample,
    output logic                                empty,
    input  wire logic                           pop,
    output logic signed [SAMPLE_BITS-1:0]       o_mean_value,
    output logic                                o_volume_end
);

    import ap3_pkg::*;

    localparam int STORE_DEPTH = MAX_CHAN * (MAX_WIDTH / 2) * (MAX_HEIGHT / 2);
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int Q_W         = ADDR_W + SAMPLE_BITS + FLAGS_W;
    localparam int OUT_W       = SAMPLE_BITS + 1;

    logic                          q_push;
    logic                          q_full;
    logic                          q_pop;
    logic                          q_empty;
    logic [ADDR_W-1:0]             q_in_addr;
    logic signed [SAMPLE_BITS-1:0] q_in_sample;
    t_item_flags                   q_in_flags;
    logic [ADDR_W-1:0]             q_out_addr;
    logic signed [SAMPLE_BITS-1:0] q_out_sample;
    t_item_flags                   q_out_flags;
    logic [Q_W-1:0]                q_out_data;

    logic                          out_push;
    logic                          out_full;
    logic signed [SAMPLE_BITS-1:0] res_mean;
    logic                          res_vend;
    logic [OUT_W-1:0]              out_data;

    // front: registers, position counters and sample classification
    ap3_front #(
        .MAX_CHAN    (MAX_CHAN),
        .MAX_WIDTH   (MAX_WIDTH),
        .MAX_HEIGHT  (MAX_HEIGHT),
        .SAMPLE_BITS (SAMPLE_BITS),
        .ADDR_W      (ADDR_W)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_push      (push),
        .o_full      (full),
        .i_sample    (i_sample),
        .o_q_push    (q_push),
        .i_q_full    (q_full),
        .o_q_addr    (q_in_addr),
        .o_q_sample  (q_in_sample),
        .o_q_flags   (q_in_flags)
    );

    // request queue between front and back
    ap3_fifo #(
        .WIDTH (Q_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_req_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  ({q_in_addr, q_in_sample, q_in_flags}),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_out_data),
        .o_empty (q_empty)
    );

    assign q_out_addr   = q_out_data[Q_W-1 -: ADDR_W];
    assign q_out_sample = q_out_data[FLAGS_W +: SAMPLE_BITS];
    assign q_out_flags  = q_out_data[FLAGS_W-1:0];

    // back: accumulate into the sum store and form the mean
    ap3_back #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .STORE_DEPTH (STORE_DEPTH),
        .ADDR_W      (ADDR_W)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_empty    (q_empty),
        .o_q_pop      (q_pop),
        .i_q_addr     (q_out_addr),
        .i_q_sample   (q_out_sample),
        .i_q_flags    (q_out_flags),
        .o_out_push   (out_push),
        .i_out_full   (out_full),
        .o_mean_value (res_mean),
        .o_volume_end (res_vend)
    );

    // result queue
    ap3_fifo #(
        .WIDTH (OUT_W),
        .DEPTH (OUT_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_data  ({res_mean, res_vend}),
        .o_full  (out_full),
        .i_pop   (pop),
        .o_data  (out_data),
        .o_empty (empty)
    );

    assign o_mean_value = out_data[OUT_W-1:1];
    assign o_volume_end = out_data[0];

endmodule

`default_nettype wire

/* design/ap3_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module ap3_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                        i_clk,
    input  wire logic                                        i_wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]                            i_wr_data,
    input  wire logic                                        i_rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]                            o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // one write port, one registered read port, read returns old data on collision
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

/* design/ap3_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none

module ap3_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic      [WIDTH-1:0] o_data,
    output logic                  o_empty
);

    localparam int PTR_W = $clog2(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W:0]   r_wr_ptr;
    logic [PTR_W:0]   r_rd_ptr;
    logic [PTR_W:0]   n_wr_ptr;
    logic [PTR_W:0]   n_rd_ptr;
    logic             do_push;
    logic             do_pop;

    // full when the pointers differ only in the wrap bit
    assign o_full  = (r_wr_ptr[PTR_W] != r_rd_ptr[PTR_W]) &&
                     (r_wr_ptr[PTR_W-1:0] == r_rd_ptr[PTR_W-1:0]);
    assign o_empty = (r_wr_ptr == r_rd_ptr);
    assign o_data  = r_mem[r_rd_ptr[PTR_W-1:0]];

    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // pointer advance
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        if (do_push) begin
            n_wr_ptr = r_wr_ptr + (PTR_W + 1)'(1);
        end
        if (do_pop) begin
            n_rd_ptr = r_rd_ptr + (PTR_W + 1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr[PTR_W-1:0]] <= i_data;
        end
    end

endmodule

`default_nettype wire

/* design/ap3_front.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "average_pool_3d_by_two_top_macros.svh"

module ap3_front #(
    parameter int MAX_CHAN    = ap3_pkg::DEF_MAX_CHAN,
    parameter int MAX_WIDTH   = ap3_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT  = ap3_pkg::DEF_MAX_HEIGHT,
    parameter int SAMPLE_BITS = ap3_pkg::DEF_SAMPLE_BITS,
    parameter int ADDR_W      = 14
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_wr_en,
    input  wire logic [ap3_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [ap3_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  wire logic                               i_push,
    output logic                                    o_full,
    input  wire logic signed [SAMPLE_BITS-1:0]      i_sample,
    output logic                                    o_q_push,
    input  wire logic                               i_q_full,
    output logic      [ADDR_W-1:0]                  o_q_addr,
    output logic signed [SAMPLE_BITS-1:0]           o_q_sample,
    output ap3_pkg::t_item_flags                    o_q_flags
);

    import ap3_pkg::*;

    localparam int CHAN_W = (MAX_CHAN > 1) ? $clog2(MAX_CHAN) : 1;
    localparam int X_W    = $clog2(MAX_WIDTH);
    localparam int Y_W    = $clog2(MAX_HEIGHT);
    localparam int NC_W   = $clog2(MAX_CHAN + 1);
    localparam int W_W    = $clog2(MAX_WIDTH + 1);
    localparam int H_W    = $clog2(MAX_HEIGHT + 1);
    localparam int D_W    = $clog2(DEPTH_LIMIT + 1);
    localparam int HALF_W = MAX_WIDTH / 2;

    logic [CH_CNT_W-1:0]  r_channel_count, n_channel_count;
    logic [SIZE_XY_W-1:0] r_input_width, n_input_width;
    logic [SIZE_XY_W-1:0] r_input_height, n_input_height;
    logic [SIZE_Z_W-1:0]  r_input_depth, n_input_depth;

    logic [CHAN_W-1:0]    r_chan_pos, n_chan_pos;
    logic [X_W-1:0]       r_x_pos, n_x_pos;
    logic [Y_W-1:0]       r_y_pos, n_y_pos;
    logic [Z_POS_W-1:0]   r_z_pos, n_z_pos;

    logic [NC_W-1:0]      nc;
    logic [W_W-1:0]       w_clamp, w_eff;
    logic [H_W-1:0]       h_clamp, h_eff;
    logic [D_W-1:0]       d_clamp, d_eff;
    logic                 chan_wrap, x_wrap, y_wrap, z_wrap;
    logic                 accept;
    logic                 cfg_hit;
    logic [ADDR_W-1:0]    cell_idx;

    // effective sizes: clamp to the supported range, sizes rounded down to even
    always_comb begin
        if (r_channel_count == '0) begin
            nc = NC_W'(1);
        end else if (32'(r_channel_count) > 32'(MAX_CHAN)) begin
            nc = NC_W'(MAX_CHAN);
        end else begin
            nc = NC_W'(r_channel_count);
        end

        if (32'(r_input_width) < 32'd2) begin
            w_clamp = W_W'(2);
        end else if (32'(r_input_width) > 32'(MAX_WIDTH)) begin
            w_clamp = W_W'(MAX_WIDTH);
        end else begin
            w_clamp = W_W'(r_input_width);
        end

        if (32'(r_input_height) < 32'd2) begin
            h_clamp = H_W'(2);
        end else if (32'(r_input_height) > 32'(MAX_HEIGHT)) begin
            h_clamp = H_W'(MAX_HEIGHT);
        end else begin
            h_clamp = H_W'(r_input_height);
        end

        if (32'(r_input_depth) < 32'd2) begin
            d_clamp = D_W'(2);
        end else if (32'(r_input_depth) > 32'(DEPTH_LIMIT)) begin
            d_clamp = D_W'(DEPTH_LIMIT);
        end else begin
            d_clamp = D_W'(r_input_depth);
        end

        w_eff = {w_clamp[W_W-1:1], 1'b0};
        h_eff = {h_clamp[H_W-1:1], 1'b0};
        d_eff = {d_clamp[D_W-1:1], 1'b0};
    end

    // position wrap detection
    assign chan_wrap = (32'(r_chan_pos) + 32'd1) >= 32'(nc);
    assign x_wrap    = (32'(r_x_pos) + 32'd1) >= 32'(w_eff);
    assign y_wrap    = (32'(r_y_pos) + 32'd1) >= 32'(h_eff);
    assign z_wrap    = (32'(r_z_pos) + 32'd1) >= 32'(d_eff);

    // request handshake into the queue
    assign accept   = i_push && !i_q_full;
    assign o_full   = i_q_full;
    assign o_q_push = accept;

    // partial-sum entry: output row, output column, channel
    assign cell_idx = (ADDR_W'(r_y_pos >> 1) * ADDR_W'(HALF_W) + ADDR_W'(r_x_pos >> 1))
                      * ADDR_W'(MAX_CHAN) + ADDR_W'(r_chan_pos);

    // classify the sample within its 2x2x2 block
    always_comb begin
        o_q_addr        = cell_idx;
        o_q_sample      = i_sample;
        o_q_flags.first = !(r_x_pos[0] || r_y_pos[0] || r_z_pos[0]);
        o_q_flags.last  = r_x_pos[0] && r_y_pos[0] && r_z_pos[0];
        o_q_flags.vend  = r_x_pos[0] && r_y_pos[0] && r_z_pos[0] &&
                          chan_wrap && x_wrap && y_wrap && z_wrap;
    end

    // register writes and position counters
    always_comb begin
        n_channel_count = r_channel_count;
        n_input_width   = r_input_width;
        n_input_height  = r_input_height;
        n_input_depth   = r_input_depth;
        n_chan_pos      = r_chan_pos;
        n_x_pos         = r_x_pos;
        n_y_pos         = r_y_pos;
        n_z_pos         = r_z_pos;
        cfg_hit         = 1'b0;

        if (i_cfg_wr_en) begin
            case (t_cfg_reg'(i_cfg_index))
                CFG_CHANNEL_COUNT: begin
                    n_channel_count = i_cfg_data[CH_CNT_W-1:0];
                    cfg_hit         = 1'b1;
                end
                CFG_INPUT_WIDTH: begin
                    n_input_width = i_cfg_data[SIZE_XY_W-1:0];
                    cfg_hit       = 1'b1;
                end
                CFG_INPUT_HEIGHT: begin
                    n_input_height = i_cfg_data[SIZE_XY_W-1:0];
                    cfg_hit        = 1'b1;
                end
                CFG_INPUT_DEPTH: begin
                    n_input_depth = i_cfg_data[SIZE_Z_W-1:0];
                    cfg_hit       = 1'b1;
                end
                default: begin
                    cfg_hit = 1'b0;
                end
            endcase
            if (cfg_hit) begin
                n_chan_pos = '0;
                n_x_pos    = '0;
                n_y_pos    = '0;
                n_z_pos    = '0;
            end
        end else if (accept) begin
            if (!chan_wrap) begin
                n_chan_pos = r_chan_pos + CHAN_W'(1);
            end else begin
                n_chan_pos = '0;
                if (!x_wrap) begin
                    n_x_pos = r_x_pos + X_W'(1);
                end else begin
                    n_x_pos = '0;
                    if (!y_wrap) begin
                        n_y_pos = r_y_pos + Y_W'(1);
                    end else begin
                        n_y_pos = '0;
                        if (!z_wrap) begin
                            n_z_pos = r_z_pos + Z_POS_W'(1);
                        end else begin
                            n_z_pos = '0;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channel_count <= CH_CNT_W'(RST_CHAN);
            r_input_width   <= SIZE_XY_W'(RST_WIDTH);
            r_input_height  <= SIZE_XY_W'(RST_HEIGHT);
            r_input_depth   <= SIZE_Z_W'(RST_DEPTH);
            r_chan_pos      <= '0;
            r_x_pos         <= '0;
            r_y_pos         <= '0;
            r_z_pos         <= '0;
        end else begin
            r_channel_count <= n_channel_count;
            r_input_width   <= n_input_width;
            r_input_height  <= n_input_height;
            r_input_depth   <= n_input_depth;
            r_chan_pos      <= n_chan_pos;
            r_x_pos         <= n_x_pos;
            r_y_pos         <= n_y_pos;
            r_z_pos         <= n_z_pos;
        end
    end

    // checks
    `AP3_ASSERT_NEXT(a_cfg_restarts, i_cfg_wr_en, (r_chan_pos == '0) && (r_x_pos == '0) && (r_y_pos == '0) && (r_z_pos == '0), "register write did not restart the volume")
    `AP3_ASSERT_IMPL(a_chan_in_range, 1'b1, 32'(r_chan_pos) < 32'(nc), "channel position beyond channel count")
    `AP3_ASSERT_IMPL(a_vend_on_last, o_q_push && o_q_flags.vend, o_q_flags.last && !o_q_flags.first, "volume end on a sample that closes no block")

endmodule

`default_nettype wire

/* design/ap3_back.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "average_pool_3d_by_two_top_macros.svh"

module ap3_back #(
    parameter int SAMPLE_BITS = ap3_pkg::DEF_SAMPLE_BITS,
    parameter int STORE_DEPTH = 16384,
    parameter int ADDR_W      = 14
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_q_empty,
    output logic                               o_q_pop,
    input  wire logic      [ADDR_W-1:0]        i_q_addr,
    input  wire logic signed [SAMPLE_BITS-1:0] i_q_sample,
    input  wire ap3_pkg::t_item_flags          i_q_flags,
    output logic                               o_out_push,
    input  wire logic                          i_out_full,
    output logic signed [SAMPLE_BITS-1:0]      o_mean_value,
    output logic                               o_volume_end
);

    import ap3_pkg::*;

    localparam int SUM_W = SAMPLE_BITS + MEAN_SHIFT;

    logic                          r_s1_valid, n_s1_valid;
    logic [ADDR_W-1:0]             r_s1_addr;
    logic signed [SAMPLE_BITS-1:0] r_s1_sample;
    t_item_flags                   r_s1_flags;
    logic                          r_fwd_hit;
    logic [SUM_W-1:0]              r_fwd_data;

    logic [SUM_W-1:0]              rd_data;
    logic [SUM_W-1:0]              base_sum;
    logic [SUM_W-1:0]              sample_ext;
    logic [SUM_W-1:0]              s1_sum;
    logic                          s1_fire;
    logic                          fwd_now;

    // stage one retires when it has no result or the output queue has room
    assign s1_fire = r_s1_valid && (!r_s1_flags.last || !i_out_full);
    assign o_q_pop = !i_q_empty && (!r_s1_valid || s1_fire);

    // a write retiring in the cycle of a read to the same entry is forwarded
    assign fwd_now = s1_fire && (r_s1_addr == i_q_addr);

    // accumulate
    always_comb begin
        sample_ext = {{MEAN_SHIFT{r_s1_sample[SAMPLE_BITS-1]}}, r_s1_sample};
        base_sum   = r_fwd_hit ? r_fwd_data : rd_data;
        s1_sum     = r_s1_flags.first ? sample_ext : base_sum + sample_ext;
    end

    // partial-sum store
    ap3_ram #(
        .WIDTH (SUM_W),
        .DEPTH (STORE_DEPTH)
    ) u_sums (
        .i_clk     (i_clk),
        .i_wr_en   (s1_fire),
        .i_wr_addr (r_s1_addr),
        .i_wr_data (s1_sum),
        .i_rd_en   (o_q_pop),
        .i_rd_addr (i_q_addr),
        .o_rd_data (rd_data)
    );

    // stage one occupancy
    always_comb begin
        n_s1_valid = r_s1_valid;
        if (o_q_pop) begin
            n_s1_valid = 1'b1;
        end else if (s1_fire) begin
            n_s1_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_fwd_hit  <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
            if (o_q_pop) begin
                r_fwd_hit <= fwd_now;
            end
        end
    end

    // stage one payload
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_s1_addr   <= i_q_addr;
            r_s1_sample <= i_q_sample;
            r_s1_flags  <= i_q_flags;
            r_fwd_data  <= s1_sum;
        end
    end

    // result: floor of the sum over eight
    assign o_out_push   = s1_fire && r_s1_flags.last;
    assign o_mean_value = s1_sum[SUM_W-1:MEAN_SHIFT];
    assign o_volume_end = r_s1_flags.vend;

    // checks
    `AP3_ASSERT_NEXT(a_fwd_capture, o_q_pop && fwd_now, r_fwd_hit,
        "same-entry write not forwarded")
    `AP3_ASSERT_NEXT(a_stall_holds, r_s1_valid && !s1_fire,
        r_s1_valid && $stable(r_s1_addr) && $stable(r_s1_flags),
        "stalled accumulate lost its item")
    `AP3_ASSERT_IMPL(a_first_not_last, r_s1_valid, !(r_s1_flags.first && r_s1_flags.last),
        "sample both opens and closes a block")

endmodule

`default_nettype wire
